>>> hdl/cws_pkg.sv
// Package for the channel waveform statistics block.
// Holds widths, limits, command codes and the sequencer state type.
// Used by channel_waveform_statistics_top and cws_checker.
package cws_pkg;

  // Channel count and sample limit per channel
  localparam int CHANNELS    = 8;
  localparam int MAX_SAMPLES = 1048576;

  // Field and accumulator widths
  localparam int CH_W    = 3;
  localparam int SMP_W   = 16;
  localparam int SQR_W   = 2 * SMP_W;
  localparam int SUM_W   = 37;
  localparam int SQ_W    = 51;
  localparam int COUNT_W = 21;
  localparam int MEAN_W  = 24;
  localparam int ROOT_W  = 24;

  // Fraction bits for mean (Q8) and for the squared mean before the root (Q16)
  localparam int MEAN_FRAC = 8;
  localparam int SQ_FRAC   = 16;

  // Shared divide / square root datapath
  localparam int MEAN_STEPS = SUM_W + MEAN_FRAC;
  localparam int RMS_STEPS  = SQ_W + SQ_FRAC;
  localparam int DVD_W      = RMS_STEPS;
  localparam int QUO_W      = 2 * ROOT_W;
  localparam int ROOT_STEPS = QUO_W / 2;
  localparam int ACC_W      = ROOT_W + 2;
  localparam int STEP_W     = $clog2(RMS_STEPS);

  localparam logic [COUNT_W-1:0] SAMPLE_LIMIT = COUNT_W'(MAX_SAMPLES);

  // Command codes
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MEAN,
    ST_RMS,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

>>> hdl/channel_waveform_statistics_top.sv
// Channel waveform statistics: per-channel max, min, peak-to-peak, mean, RMS.
// Depends on cws_pkg for widths, command codes and the state type.
//
// Each transfer on the item channel carries a command, a channel and a sample.
// An add squares the sample, then accumulates it; a clear and a command code
// with no meaning are done at accept. A report on an empty channel goes
// straight to the done state; for a report on a channel with samples, one
// 26-bit subtract/compare unit is stepped one bit per cycle through the mean
// division (45 steps), the mean-square division (67 steps) and the square
// root (24 steps). item_stall is high for the whole time an item is at work.
// A finished report sits in an output register; the block takes the next item
// while it waits there, and only a second report waits for it to be taken.
module channel_waveform_statistics_top
  import cws_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // item channel
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [1:0]                command,
  input  logic [CH_W-1:0]           channel,
  input  logic signed [SMP_W-1:0]   sample,
  // result channel
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [CH_W-1:0]           report_channel,
  output logic                      is_empty,
  output logic signed [SMP_W-1:0]   peak_max,
  output logic signed [SMP_W-1:0]   peak_min,
  output logic [SMP_W-1:0]          peak_to_peak,
  output logic signed [MEAN_W-1:0]  mean_q8,
  output logic [ROOT_W-1:0]         rms_q8,
  output logic [COUNT_W-1:0]        sample_count,
  output logic                      count_overflow
);

  // Per-channel running statistics
  logic signed [SMP_W-1:0]   run_max        [CHANNELS];
  logic signed [SMP_W-1:0]   run_min        [CHANNELS];
  logic signed [SUM_W-1:0]   run_sum        [CHANNELS];
  logic [SQ_W-1:0]           run_square_sum [CHANNELS];
  logic [COUNT_W-1:0]        run_count      [CHANNELS];
  logic                      dropped_flag   [CHANNELS];

  // Sequencer
  state_t                    state, state_next;
  logic [STEP_W-1:0]         step_cnt;
  logic                      accept;
  logic                      out_free;
  logic                      load_result;
  logic                      ch_ok;
  logic                      last_step;

  // Item registers
  logic [CH_W-1:0]           cur_ch;
  logic signed [SMP_W-1:0]   cur_sample;
  logic [SQR_W-1:0]          cur_square;
  logic signed [SQR_W-1:0]   prod;

  // Report working registers
  logic                      work_empty;
  logic                      work_neg;
  logic [SQ_W-1:0]           work_sq;
  logic [COUNT_W-1:0]        work_cnt;
  logic signed [SMP_W-1:0]   work_max;
  logic signed [SMP_W-1:0]   work_min;
  logic                      work_flag;
  logic [MEAN_W-1:0]         mean_mag;

  // Shared divide / root datapath
  logic [DVD_W-1:0]          dvd;
  logic [QUO_W-1:0]          quo;
  logic [QUO_W-1:0]          quo_shift;
  logic [ACC_W-1:0]          acc;
  logic [ROOT_W-1:0]         root;
  logic [ACC_W-1:0]          sub_a, sub_b;
  logic [ACC_W:0]            diff;
  logic                      ge;

  // Read of the addressed channel at accept
  logic signed [SUM_W-1:0]   rd_sum;
  logic [SUM_W-1:0]          sum_mag;
  logic [COUNT_W-1:0]        rd_cnt;
  logic signed [SMP_W:0]     pp_wide;

  assign accept  = item_valid && !item_stall;
  assign ch_ok   = (32'(channel) < CHANNELS);
  assign prod    = sample * sample;
  assign rd_sum  = run_sum[channel];
  assign rd_cnt  = run_count[channel];
  assign sum_mag = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);
  assign last_step = (step_cnt == '0);
  assign pp_wide = {work_max[SMP_W-1], work_max} - {work_min[SMP_W-1], work_min};

  // Shared subtract/compare: restoring divide step or square root step
  always_comb begin
    if (state == ST_ROOT) begin
      sub_a = {acc[ACC_W-3:0], quo[QUO_W-1 -: 2]};
      sub_b = {root, 2'b01};
    end else begin
      sub_a = {acc[ACC_W-2:0], dvd[DVD_W-1]};
      sub_b = ACC_W'(work_cnt);
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = !diff[ACC_W];
    quo_shift = {quo[QUO_W-2:0], ge};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(command))
            CMD_ADD:    state_next = ch_ok ? ST_ADD : ST_IDLE;
            CMD_REPORT: state_next = (!ch_ok || rd_cnt == '0) ? ST_DONE : ST_MEAN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD:  state_next = ST_IDLE;
      ST_MEAN: if (last_step) state_next = ST_RMS;
      ST_RMS:  if (last_step) state_next = ST_ROOT;
      ST_ROOT: if (last_step) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_stall  = (state != ST_IDLE);
    out_free    = !result_valid || !result_stall;
    load_result = (state == ST_DONE) && out_free;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: step_cnt <= STEP_W'(MEAN_STEPS - 1);
        ST_MEAN: step_cnt <= last_step ? STEP_W'(RMS_STEPS - 1) : step_cnt - 1'b1;
        ST_RMS:  step_cnt <= last_step ? STEP_W'(ROOT_STEPS - 1) : step_cnt - 1'b1;
        ST_ROOT: step_cnt <= step_cnt - 1'b1;
        default: step_cnt <= step_cnt;
      endcase
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Running statistics: clear on accept, accumulate in the add step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        run_max[c]        <= {1'b1, {(SMP_W-1){1'b0}}};
        run_min[c]        <= {1'b0, {(SMP_W-1){1'b1}}};
        run_sum[c]        <= '0;
        run_square_sum[c] <= '0;
        run_count[c]      <= '0;
        dropped_flag[c]   <= 1'b0;
      end
    end else if (accept && cmd_t'(command) == CMD_CLEAR && ch_ok) begin
      run_max[channel]        <= {1'b1, {(SMP_W-1){1'b0}}};
      run_min[channel]        <= {1'b0, {(SMP_W-1){1'b1}}};
      run_sum[channel]        <= '0;
      run_square_sum[channel] <= '0;
      run_count[channel]      <= '0;
      dropped_flag[channel]   <= 1'b0;
    end else if (state == ST_ADD) begin
      if (run_count[cur_ch] >= SAMPLE_LIMIT) begin
        dropped_flag[cur_ch] <= 1'b1;
      end else begin
        if (cur_sample > run_max[cur_ch]) run_max[cur_ch] <= cur_sample;
        if (cur_sample < run_min[cur_ch]) run_min[cur_ch] <= cur_sample;
        run_sum[cur_ch] <= run_sum[cur_ch]
                         + {{(SUM_W-SMP_W){cur_sample[SMP_W-1]}}, cur_sample};
        run_square_sum[cur_ch] <= run_square_sum[cur_ch] + SQ_W'(cur_square);
        run_count[cur_ch] <= run_count[cur_ch] + 1'b1;
      end
    end
  end

  // Datapath: capture, divide steps, root steps
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cur_ch     <= channel;
          cur_sample <= sample;
          cur_square <= unsigned'(prod);
          work_empty <= !ch_ok || rd_cnt == '0;
          work_neg   <= rd_sum[SUM_W-1];
          work_sq    <= run_square_sum[channel];
          work_cnt   <= rd_cnt;
          work_max   <= run_max[channel];
          work_min   <= run_min[channel];
          work_flag  <= dropped_flag[channel];
          dvd        <= {sum_mag, {(DVD_W-SUM_W){1'b0}}};
          acc        <= '0;
          quo        <= '0;
        end
      end
      ST_MEAN: begin
        if (last_step) begin
          mean_mag <= quo_shift[MEAN_W-1:0];
          dvd      <= {work_sq, {SQ_FRAC{1'b0}}};
          acc      <= '0;
          quo      <= '0;
        end else begin
          dvd <= {dvd[DVD_W-2:0], 1'b0};
          acc <= ge ? diff[ACC_W-1:0] : sub_a;
          quo <= quo_shift;
        end
      end
      ST_RMS: begin
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        quo <= quo_shift;
        if (last_step) begin
          acc  <= '0;
          root <= '0;
        end else begin
          acc <= ge ? diff[ACC_W-1:0] : sub_a;
        end
      end
      ST_ROOT: begin
        acc  <= ge ? diff[ACC_W-1:0] : sub_a;
        quo  <= {quo[QUO_W-3:0], 2'b00};
        root <= {root[ROOT_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_result) begin
      report_channel <= cur_ch;
      is_empty       <= work_empty;
      if (work_empty) begin
        peak_max       <= '0;
        peak_min       <= '0;
        peak_to_peak   <= '0;
        mean_q8        <= '0;
        rms_q8         <= '0;
        sample_count   <= '0;
        count_overflow <= 1'b0;
      end else begin
        peak_max       <= work_max;
        peak_min       <= work_min;
        peak_to_peak   <= pp_wide[SMP_W-1:0];
        mean_q8        <= work_neg ? MEAN_W'(-signed'(mean_mag)) : signed'(mean_mag);
        rms_q8         <= root;
        sample_count   <= work_cnt;
        count_overflow <= work_flag;
      end
    end
  end

endmodule

>>> hdl/cws_checker.sv
// Port-level checker for channel_waveform_statistics_top, with its bind.
// Depends on cws_pkg for widths and command codes.
module cws_checker
  import cws_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_stall,
  input logic [1:0]                command,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic [CH_W-1:0]           report_channel,
  input logic                      is_empty,
  input logic signed [SMP_W-1:0]   peak_max,
  input logic signed [SMP_W-1:0]   peak_min,
  input logic [SMP_W-1:0]          peak_to_peak,
  input logic signed [MEAN_W-1:0]  mean_q8,
  input logic [ROOT_W-1:0]         rms_q8,
  input logic [COUNT_W-1:0]        sample_count,
  input logic                      count_overflow
);

  // A stalled result stays and holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(report_channel)
      && $stable(is_empty) && $stable(mean_q8) && $stable(rms_q8)
      && $stable(sample_count))
    else $error("stalled result changed");

  // Empty report carries zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_empty |-> peak_max == '0 && peak_min == '0
      && peak_to_peak == '0 && mean_q8 == '0 && rms_q8 == '0
      && sample_count == '0 && !count_overflow)
    else $error("empty report with nonzero fields");

  // Non-empty report is consistent
  a_report_sane: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_empty |-> sample_count != '0 && peak_max >= peak_min
      && peak_to_peak == SMP_W'(peak_max - peak_min))
    else $error("inconsistent report");

  // An add transfer keeps the item side busy for the accumulate cycle
  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && command == CMD_ADD |=> item_stall)
    else $error("add transfer did not stall the next cycle");

endmodule

bind channel_waveform_statistics_top cws_checker u_cws_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for channel_waveform_statistics_top: directed and random traffic.
// Depends on cws_pkg and the block's RTL; the channel model lives in the class below.
import cws_pkg::*;

// One expected or observed statistics report
typedef struct {
  logic [CH_W-1:0]          report_channel;
  logic                     is_empty;
  logic signed [SMP_W-1:0]  peak_max;
  logic signed [SMP_W-1:0]  peak_min;
  logic [SMP_W-1:0]         peak_to_peak;
  logic signed [MEAN_W-1:0] mean_q8;
  logic [ROOT_W-1:0]        rms_q8;
  logic [COUNT_W-1:0]       sample_count;
  logic                     count_overflow;
} stats_report_t;

// Tracks per-channel running statistics and the reports they should produce
class channel_stats_tracker;
  logic signed [SMP_W-1:0]  peak_hi [CHANNELS];
  logic signed [SMP_W-1:0]  peak_lo [CHANNELS];
  logic signed [SUM_W-1:0]  sample_total [CHANNELS];
  logic [SQ_W-1:0]          square_total [CHANNELS];
  logic [COUNT_W-1:0]       taken [CHANNELS];
  logic                     dropped [CHANNELS];
  stats_report_t            report_q [$];
  int unsigned              error_count;

  function new();
    error_count = 0;
    for (int c = 0; c < CHANNELS; c++) clear_channel(c);
  endfunction

  function void clear_channel(int c);
    peak_hi[c]      = 16'sh8000;
    peak_lo[c]      = 16'sh7fff;
    sample_total[c] = '0;
    square_total[c] = '0;
    taken[c]        = '0;
    dropped[c]      = 1'b0;
  endfunction

  function int pending();
    return report_q.size();
  endfunction

  // Fold one accepted transfer into the channel state; queue a report if asked
  function void fold_item(cmd_t op, logic [CH_W-1:0] ch, logic signed [SMP_W-1:0] s);
    stats_report_t want;
    longint unsigned n, mag, mq, q, r, scaled, root, trial;
    longint total, mean, wide_s;
    bit in_range;
    in_range = ch < CHANNELS;
    case (op)
      CMD_ADD: begin
        if (in_range) begin
          if (taken[ch] >= MAX_SAMPLES) begin
            dropped[ch] = 1'b1;
          end else begin
            if (s > peak_hi[ch]) peak_hi[ch] = s;
            if (s < peak_lo[ch]) peak_lo[ch] = s;
            wide_s = s;
            sample_total[ch] = sample_total[ch] + wide_s;
            square_total[ch] = square_total[ch] + wide_s * wide_s;
            taken[ch] = taken[ch] + 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        if (in_range) clear_channel(ch);
      end
      CMD_REPORT: begin
        want.report_channel = ch;
        want.is_empty       = 1'b1;
        want.peak_max       = '0;
        want.peak_min       = '0;
        want.peak_to_peak   = '0;
        want.mean_q8        = '0;
        want.rms_q8         = '0;
        want.sample_count   = '0;
        want.count_overflow = 1'b0;
        if (in_range && taken[ch] != 0) begin
          n     = taken[ch];
          total = sample_total[ch];
          // mean: magnitude divided, sign put back, so it truncates toward zero
          mag  = total < 0 ? -total : total;
          mq   = (mag << MEAN_FRAC) / n;
          mean = total < 0 ? -longint'(mq) : longint'(mq);
          // mean square in Q16, then floor square root bit by bit
          q      = square_total[ch] / n;
          r      = square_total[ch] % n;
          scaled = (q << SQ_FRAC) + ((r << SQ_FRAC) / n);
          root   = 0;
          for (int b = 25; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= scaled) root = trial;
          end
          want.is_empty       = 1'b0;
          want.peak_max       = peak_hi[ch];
          want.peak_min       = peak_lo[ch];
          want.peak_to_peak   = peak_hi[ch] - peak_lo[ch];
          want.mean_q8        = mean[MEAN_W-1:0];
          want.rms_q8         = root[ROOT_W-1:0];
          want.sample_count   = taken[ch];
          want.count_overflow = dropped[ch];
        end
        report_q.push_back(want);
      end
      default: ;
    endcase
  endfunction

  function void check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Compare one accepted report with the oldest expected one
  function void check_report(stats_report_t got);
    stats_report_t want;
    if (report_q.size() == 0) begin
      $error("report for channel %0d with none expected", got.report_channel);
      error_count++;
      return;
    end
    want = report_q.pop_front();
    check_field("report_channel", want.report_channel, got.report_channel);
    check_field("is_empty", want.is_empty, got.is_empty);
    check_field("peak_max", want.peak_max, got.peak_max);
    check_field("peak_min", want.peak_min, got.peak_min);
    check_field("peak_to_peak", want.peak_to_peak, got.peak_to_peak);
    check_field("mean_q8", want.mean_q8, got.mean_q8);
    check_field("rms_q8", want.rms_q8, got.rms_q8);
    check_field("sample_count", want.sample_count, got.sample_count);
    check_field("count_overflow", want.count_overflow, got.count_overflow);
  endfunction
endclass

module tb_top;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASE_ITEMS  = 150;

  logic                     clk;
  logic                     rst;
  logic                     item_valid;
  logic                     item_stall;
  logic [1:0]               command;
  logic [CH_W-1:0]          channel;
  logic signed [SMP_W-1:0]  sample;
  logic                     result_valid;
  logic                     result_stall;
  logic [CH_W-1:0]          report_channel;
  logic                     is_empty;
  logic signed [SMP_W-1:0]  peak_max;
  logic signed [SMP_W-1:0]  peak_min;
  logic [SMP_W-1:0]         peak_to_peak;
  logic signed [MEAN_W-1:0] mean_q8;
  logic [ROOT_W-1:0]        rms_q8;
  logic [COUNT_W-1:0]       sample_count;
  logic                     count_overflow;

  channel_stats_tracker stats_model;
  stats_report_t        seen_report;
  int                   src_idle_pct;
  int                   dst_stall_pct;

  channel_waveform_statistics_top dut (.*);

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver back-pressure
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall)
        stats_model.fold_item(cmd_t'(command), channel, sample);
      if (result_valid && !result_stall) begin
        seen_report.report_channel = report_channel;
        seen_report.is_empty       = is_empty;
        seen_report.peak_max       = peak_max;
        seen_report.peak_min       = peak_min;
        seen_report.peak_to_peak   = peak_to_peak;
        seen_report.mean_q8        = mean_q8;
        seen_report.rms_q8         = rms_q8;
        seen_report.sample_count   = sample_count;
        seen_report.count_overflow = count_overflow;
        stats_model.check_report(seen_report);
      end
    end
  end

  function automatic void set_idling(int src, int dst);
    src_idle_pct  = src;
    dst_stall_pct = dst;
  endfunction

  // Mix of full-scale, small and arbitrary sample values
  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SMP_W'($urandom_range(16) - 8);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Drive one transfer; entered and left just after a falling edge
  task automatic send_item(cmd_t op, logic [CH_W-1:0] ch, logic signed [SMP_W-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    command    <= op;
    channel    <= ch;
    sample     <= s;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int          done_items;
    int          burst;
    cmd_t        op;
    logic [CH_W-1:0] ch;
    rst          = 1'b1;
    item_valid   = 1'b0;
    command      = CMD_ADD;
    channel      = '0;
    sample       = '0;
    result_stall = 1'b0;
    set_idling(0, 0);
    stats_model = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty channel, unused command, extremes, truncation, clear
    send_item(CMD_REPORT, 3'd0, 16'sd0);
    send_item(CMD_NONE, 3'd0, 16'sh1234);
    send_item(CMD_REPORT, 3'd0, 16'sd0);
    send_item(CMD_ADD, 3'd1, 16'sh7fff);
    send_item(CMD_ADD, 3'd1, 16'sh8000);
    send_item(CMD_REPORT, 3'd1, 16'sd0);
    send_item(CMD_ADD, 3'd2, 16'sh7fff);
    send_item(CMD_REPORT, 3'd2, 16'shffff);
    send_item(CMD_ADD, 3'd3, 16'sh8000);
    send_item(CMD_REPORT, 3'd3, 16'sd0);
    send_item(CMD_ADD, 3'd4, 16'sd0);
    send_item(CMD_REPORT, 3'd4, 16'sd0);
    send_item(CMD_ADD, 3'd6, -16'sd1);
    send_item(CMD_ADD, 3'd6, 16'sd0);
    send_item(CMD_ADD, 3'd6, 16'sd0);
    send_item(CMD_REPORT, 3'd6, 16'sd0);
    send_item(CMD_CLEAR, 3'd1, 16'sh5a5a);
    send_item(CMD_REPORT, 3'd1, 16'sd0);
    send_item(CMD_NONE, 3'd7, 16'sh5a5a);
    send_item(CMD_REPORT, 3'd7, 16'sd0);
    send_item(CMD_CLEAR, 3'd0, 16'sd0);
    send_item(CMD_REPORT, 3'd0, 16'sd0);

    // Random: mostly bursts of adds closed by a report, some loose traffic
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      case ((done_items / PHASE_ITEMS) % 4)
        0:       set_idling(0, 0);
        1:       set_idling(68, 0);
        2:       set_idling(0, 68);
        default: set_idling(12, 12);
      endcase
      if ($urandom_range(99) < 80) begin
        ch    = CH_W'($urandom_range(CHANNELS - 1));
        burst = $urandom_range(12, 1);
        repeat (burst) send_item(CMD_ADD, ch, pick_sample());
        send_item(CMD_REPORT, ch, SMP_W'($urandom));
        done_items += burst + 1;
        if ($urandom_range(99) < 20) begin
          send_item(CMD_CLEAR, ch, SMP_W'($urandom));
          done_items++;
        end
      end else begin
        op = cmd_t'($urandom_range(3));
        send_item(op, CH_W'($urandom), pick_sample());
        if (op != CMD_NONE) done_items++;
      end
    end
    item_valid <= 1'b0;

    // Drain, then watch a while for stray reports
    while (stats_model.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (stats_model.error_count == 0 && stats_model.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule
